[rtl/core/ptmc_pkg.sv]
package ptmc_pkg;

   // field widths
   localparam int COORD_BITS = 16;
   localparam int RUN_BITS   = 12;
   localparam int CELL_BITS  = 16;
   localparam int DIST_BITS  = RUN_BITS + CELL_BITS;
   localparam int HEAD_BITS  = 2;
   localparam int TURN_BITS  = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // command kinds
   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_ROTATE    = 1'b1;

   // turn codes
   localparam logic [TURN_BITS-1:0] TURN_RIGHT = 2'd0;
   localparam logic [TURN_BITS-1:0] TURN_LEFT  = 2'd1;
   localparam logic [TURN_BITS-1:0] TURN_UTURN = 2'd2;
   localparam logic [TURN_BITS-1:0] TURN_NONE  = 2'd0;

   // headings
   localparam logic [HEAD_BITS-1:0] HEAD_N = 2'd0;
   localparam logic [HEAD_BITS-1:0] HEAD_E = 2'd1;
   localparam logic [HEAD_BITS-1:0] HEAD_S = 2'd2;
   localparam logic [HEAD_BITS-1:0] HEAD_W = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_SIZE    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_ENABLE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_HEAD   = 2'd2;

   localparam logic [CELL_BITS-1:0] CELL_SIZE_RESET = 16'd100;

   // progress through a path
   localparam logic [1:0] SEEN_NONE  = 2'd0;
   localparam logic [1:0] SEEN_FIRST = 2'd1;
   localparam logic [1:0] SEEN_RUN   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic                  last_cell;
   } req_word_type;

   typedef struct packed {
      logic                  cmd_kind;
      logic [TURN_BITS-1:0]  turn;
      logic [RUN_BITS-1:0]   steps;
      logic [DIST_BITS-1:0]  distance;
      logic                  end_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] cell_size;
      logic                 start_heading_enable;
      logic [HEAD_BITS-1:0] start_heading;
   } csr_regs_type;

   // results caused by one input word, always in the order t1, rotate, t2
   typedef struct packed {
      logic                 t1_valid;
      logic [RUN_BITS-1:0]  t1_steps;
      logic                 rot_valid;
      logic [TURN_BITS-1:0] rot_turn;
      logic                 t2_valid;
      logic [RUN_BITS-1:0]  t2_steps;
   } cmd_group_type;

   // turn from one heading to another that differs from it
   function automatic logic [TURN_BITS-1:0] turn_between(
      logic [HEAD_BITS-1:0] from_h, logic [HEAD_BITS-1:0] to_h);
      logic [HEAD_BITS-1:0] d;
      d = to_h - from_h;
      case (d)
         HEAD_E:  turn_between = TURN_LEFT;
         HEAD_S:  turn_between = TURN_UTURN;
         default: turn_between = TURN_RIGHT;
      endcase
   endfunction

endpackage

[rtl/core/ptmc_front.sv]
module ptmc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ptmc_pkg::req_word_type req_word,
   input  ptmc_pkg::csr_regs_type csr_regs,
   output logic                  push_valid,
   output ptmc_pkg::cmd_group_type push_word,
   input  logic                  q_full
);
   import ptmc_pkg::*;

   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   logic [COORD_BITS-1:0] prev_row_ff, prev_row_in;
   logic [COORD_BITS-1:0] prev_col_ff, prev_col_in;
   logic [1:0]            seen_ff, seen_in;
   logic [HEAD_BITS-1:0]  heading_ff, heading_in;
   logic [RUN_BITS-1:0]   run_ff, run_in;
   logic                  dead_ff, dead_in;

   logic [COORD_BITS:0]   row_x, col_x, prow_x, pcol_x;
   logic                  same_row, same_col;
   logic                  unit_step;
   logic [HEAD_BITS-1:0]  step_head;
   logic                  accept;
   cmd_group_type         group;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // classify the step from the previous cell
   assign row_x  = {1'b0, req_word.row};
   assign col_x  = {1'b0, req_word.col};
   assign prow_x = {1'b0, prev_row_ff};
   assign pcol_x = {1'b0, prev_col_ff};
   assign same_row = (req_word.row == prev_row_ff);
   assign same_col = (req_word.col == prev_col_ff);

   always_comb begin
      unit_step = 1'b1;
      step_head = HEAD_N;
      if (same_col && (row_x + 1'b1 == prow_x)) begin
         step_head = HEAD_N;
      end else if (same_row && (col_x == pcol_x + 1'b1)) begin
         step_head = HEAD_E;
      end else if (same_col && (row_x == prow_x + 1'b1)) begin
         step_head = HEAD_S;
      end else if (same_row && (col_x + 1'b1 == pcol_x)) begin
         step_head = HEAD_W;
      end else begin
         unit_step = 1'b0;
      end
   end

   // path state update and command group
   always_comb begin
      prev_row_in = req_word.row;
      prev_col_in = req_word.col;
      seen_in     = seen_ff;
      heading_in  = heading_ff;
      run_in      = run_ff;
      dead_in     = dead_ff;
      group       = '0;
      if (!dead_ff && seen_ff != SEEN_NONE) begin
         if (seen_ff == SEEN_FIRST) begin
            if (!unit_step) begin
               dead_in = 1'b1;
            end else begin
               heading_in = step_head;
               run_in     = RUN_BITS'(1);
               seen_in    = SEEN_RUN;
               if (csr_regs.start_heading_enable && step_head != csr_regs.start_heading) begin
                  group.rot_valid = 1'b1;
                  group.rot_turn  = turn_between(csr_regs.start_heading, step_head);
               end
            end
         end else if (unit_step) begin
            if (step_head == heading_ff) begin
               if (run_ff < RUN_MAX) begin
                  run_in = run_ff + 1'b1;
               end
            end else begin
               group.t1_valid  = 1'b1;
               group.t1_steps  = run_ff;
               group.rot_valid = 1'b1;
               group.rot_turn  = turn_between(heading_ff, step_head);
               heading_in      = step_head;
               run_in          = RUN_BITS'(1);
            end
         end
      end else if (seen_ff == SEEN_NONE) begin
         seen_in = SEEN_FIRST;
      end
      // end of path: final run, then back to the reset state
      if (req_word.last_cell) begin
         if (!dead_in && seen_in == SEEN_RUN) begin
            group.t2_valid = 1'b1;
            group.t2_steps = run_in;
         end
         prev_row_in = '0;
         prev_col_in = '0;
         seen_in     = SEEN_NONE;
         heading_in  = HEAD_N;
         run_in      = '0;
         dead_in     = 1'b0;
      end
   end

   assign push_valid = accept && (group.t1_valid || group.rot_valid || group.t2_valid);
   assign push_word  = group;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_row_ff <= '0;
         prev_col_ff <= '0;
         seen_ff     <= SEEN_NONE;
         heading_ff  <= HEAD_N;
         run_ff      <= '0;
         dead_ff     <= 1'b0;
      end else if (accept) begin
         prev_row_ff <= prev_row_in;
         prev_col_ff <= prev_col_in;
         seen_ff     <= seen_in;
         heading_ff  <= heading_in;
         run_ff      <= run_in;
         dead_ff     <= dead_in;
      end
   end

endmodule

[rtl/core/ptmc_queue.sv]
module ptmc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptmc_pkg::cmd_group_type push_word,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output ptmc_pkg::cmd_group_type head_word
);
   import ptmc_pkg::*;

   cmd_group_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_word = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[rtl/core/ptmc_back.sv]
module ptmc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ptmc_pkg::CELL_BITS-1:0] cell_size,
   input  logic                    q_empty,
   input  ptmc_pkg::cmd_group_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ptmc_pkg::rsp_word_type  rsp_word
);
   import ptmc_pkg::*;

   cmd_group_type        cur_ff, cur_in;
   logic [2:0]           pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                 out_free;
   logic                 emit;
   logic [2:0]           sel;
   logic [2:0]           remain;
   logic [RUN_BITS-1:0]  sel_steps;
   logic [DIST_BITS-1:0] product;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = out_free && (pend_ff != '0);

   // pick the earliest pending result of the current group
   always_comb begin
      sel = 3'b000;
      if (pend_ff[0]) begin
         sel = 3'b001;
      end else if (pend_ff[1]) begin
         sel = 3'b010;
      end else if (pend_ff[2]) begin
         sel = 3'b100;
      end
   end

   assign remain    = pend_ff & ~sel;
   assign sel_steps = sel[0] ? cur_ff.t1_steps : cur_ff.t2_steps;
   assign product   = DIST_BITS'(sel_steps) * DIST_BITS'(cell_size);

   // result word
   always_comb begin
      rsp_word_in            = '0;
      rsp_word_in.end_of_run = (remain == '0);
      if (sel[1]) begin
         rsp_word_in.cmd_kind = CMD_ROTATE;
         rsp_word_in.turn     = cur_ff.rot_turn;
      end else begin
         rsp_word_in.cmd_kind = CMD_TRANSLATE;
         rsp_word_in.turn     = TURN_NONE;
         rsp_word_in.steps    = sel_steps;
         rsp_word_in.distance = product;
      end
   end

   // load the next group once the current one is used up
   always_comb begin
      q_pop  = 1'b0;
      cur_in = cur_ff;
      pend_in = emit ? remain : pend_ff;
      if (out_free && (pend_ff == '0 || remain == '0) && !q_empty) begin
         q_pop   = 1'b1;
         cur_in  = q_head;
         pend_in = {q_head.t2_valid, q_head.rot_valid, q_head.t1_valid};
      end
   end

   // output register
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/core/path_to_motion_commands_top.sv]
// path to motion commands
// req channel: one path cell per word (row, col, last_cell), valid/ready.
// rsp channel: motion commands (translate or rotate), valid/ready; end_of_run
//   marks the last command caused by one input word.
// csr channel: register writes (index, data), always ready; index 0 cell size,
//   1 start heading enable, 2 start heading; other indexes are dropped.
// a front stage classifies each cell and queues the commands it causes in a
//   four-entry queue; a back stage emits them one per cycle while rsp_ready
//   holds, from an output register, with one 12x16 multiply for distance.
// throughput: one cell per cycle while the queue has room; a cell that causes
//   k commands holds the back stage until all k of them are emitted.
// a command passes through the queue and the output register on its way to rsp.
// reset: registers return to their defaults, path state, queue and output
//   register valid are cleared.
// when the receiver stalls the output word holds, the queue fills and
//   req_ready drops once it is full; last_cell also returns the path state
//   to its reset values.
module path_to_motion_commands_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ptmc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptmc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ptmc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ptmc_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import ptmc_pkg::*;

   csr_regs_type  csr_ff, csr_in;
   logic          q_push, q_full, q_pop, q_empty;
   cmd_group_type q_in_word, q_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CELL_SIZE:    csr_in.cell_size = csr_data[CELL_BITS-1:0];
            CSR_START_ENABLE: csr_in.start_heading_enable = csr_data[0];
            CSR_START_HEAD:   csr_in.start_heading = csr_data[HEAD_BITS-1:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.cell_size            <= CELL_SIZE_RESET;
         csr_ff.start_heading_enable <= 1'b0;
         csr_ff.start_heading        <= HEAD_N;
      end else begin
         csr_ff <= csr_in;
      end
   end

   ptmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .csr_regs   (csr_ff),
      .push_valid (q_push),
      .push_word  (q_in_word),
      .q_full     (q_full)
   );

   ptmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_word (q_head)
   );

   ptmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cell_size (csr_ff.cell_size),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // no push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   // rotate words carry no distance
   a_rotate_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.cmd_kind == CMD_ROTATE) |->
      (rsp_word.steps == '0 && rsp_word.distance == '0))
      else $error("rotate word with distance");

   // translate words cover at least one cell and carry no turn
   a_translate_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.cmd_kind == CMD_TRANSLATE) |->
      (rsp_word.steps != '0 && rsp_word.turn == TURN_NONE))
      else $error("empty translate word");

   // output register is empty after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   import ptmc_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   // expected command words and the path tracking that produces them
   class motion_scoreboard;
      rsp_word_type          expected_cmds[$];
      logic [CELL_BITS-1:0]  cell_size;
      logic                  start_enable;
      logic [HEAD_BITS-1:0]  start_head;
      logic [COORD_BITS-1:0] prev_row;
      logic [COORD_BITS-1:0] prev_col;
      logic [1:0]            cells_seen;
      logic [HEAD_BITS-1:0]  heading;
      logic [RUN_BITS-1:0]   run_length;
      logic                  path_dead;
      int                    cells_taken;
      int                    paths_closed;
      int                    cmds_checked;
      int                    failures;

      function new();
         cell_size    = CELL_SIZE_RESET;
         start_enable = 1'b0;
         start_head   = HEAD_N;
         cells_taken  = 0;
         paths_closed = 0;
         cmds_checked = 0;
         failures     = 0;
         clear_path();
      endfunction

      function void clear_path();
         prev_row   = '0;
         prev_col   = '0;
         cells_seen = SEEN_NONE;
         heading    = HEAD_N;
         run_length = '0;
         path_dead  = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_CELL_SIZE:    cell_size = data[CELL_BITS-1:0];
            CSR_START_ENABLE: start_enable = data[0];
            CSR_START_HEAD:   start_head = data[HEAD_BITS-1:0];
            default: ;
         endcase
      endfunction

      // heading difference counted in quarter turns
      function logic [TURN_BITS-1:0] turn_code(logic [HEAD_BITS-1:0] from_h,
                                               logic [HEAD_BITS-1:0] to_h);
         logic [HEAD_BITS-1:0] quarters;
         quarters = to_h - from_h;
         if (quarters == 2'd1) return TURN_LEFT;
         if (quarters == 2'd2) return TURN_UTURN;
         return TURN_RIGHT;
      endfunction

      // exact signed difference against the previous cell
      function bit unit_step(req_word_type w, output logic [HEAD_BITS-1:0] h);
         int dr;
         int dc;
         dr = int'(w.row) - int'(prev_row);
         dc = int'(w.col) - int'(prev_col);
         h = HEAD_N;
         if (dr == -1 && dc == 0) return 1'b1;
         if (dr == 0 && dc == 1) begin
            h = HEAD_E;
            return 1'b1;
         end
         if (dr == 1 && dc == 0) begin
            h = HEAD_S;
            return 1'b1;
         end
         if (dr == 0 && dc == -1) begin
            h = HEAD_W;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function rsp_word_type translate_cmd();
         rsp_word_type c;
         logic [DIST_BITS-1:0] a;
         logic [DIST_BITS-1:0] b;
         a = DIST_BITS'(run_length);
         b = DIST_BITS'(cell_size);
         c = '0;
         c.cmd_kind = CMD_TRANSLATE;
         c.turn     = TURN_NONE;
         c.steps    = run_length;
         c.distance = a * b;
         return c;
      endfunction

      function rsp_word_type rotate_cmd(logic [TURN_BITS-1:0] t);
         rsp_word_type c;
         c = '0;
         c.cmd_kind = CMD_ROTATE;
         c.turn     = t;
         return c;
      endfunction

      // accepted cell: advance the path and queue the commands it causes
      function void note_cell(req_word_type w);
         rsp_word_type group[3];
         int n;
         int i;
         logic [HEAD_BITS-1:0] h;
         bit unit;
         n = 0;
         cells_taken++;
         if (!path_dead && cells_seen != SEEN_NONE) begin
            unit = unit_step(w, h);
            if (cells_seen == SEEN_FIRST) begin
               if (!unit) path_dead = 1'b1;
               else begin
                  heading    = h;
                  run_length = RUN_BITS'(1);
                  cells_seen = SEEN_RUN;
                  if (start_enable && h != start_head) begin
                     group[n] = rotate_cmd(turn_code(start_head, h));
                     n++;
                  end
               end
            end else if (unit) begin
               if (h == heading) begin
                  // run count saturates
                  if (run_length != '1) run_length++;
               end else begin
                  group[n] = translate_cmd();
                  n++;
                  group[n] = rotate_cmd(turn_code(heading, h));
                  n++;
                  heading    = h;
                  run_length = RUN_BITS'(1);
               end
            end
         end else if (cells_seen == SEEN_NONE) begin
            cells_seen = SEEN_FIRST;
         end
         prev_row = w.row;
         prev_col = w.col;
         if (w.last_cell) begin
            if (!path_dead && cells_seen == SEEN_RUN) begin
               group[n] = translate_cmd();
               n++;
            end
            clear_path();
            paths_closed++;
         end
         if (n > 0) group[n-1].end_of_run = 1'b1;
         for (i = 0; i < n; i++) expected_cmds = {expected_cmds, group[i]};
      endfunction

      function void check_command(rsp_word_type got);
         rsp_word_type want;
         if (expected_cmds.size() == 0) begin
            failures++;
            if (failures <= 10) $display("%0t: command word %h with none expected", $time, got);
            return;
         end
         want = expected_cmds.pop_front();
         cmds_checked++;
         if (got.cmd_kind !== want.cmd_kind || got.turn !== want.turn ||
             got.steps !== want.steps || got.distance !== want.distance ||
             got.end_of_run !== want.end_of_run) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: expected kind %0d turn %0d steps %0d distance %0d end %0d",
                        $time, want.cmd_kind, want.turn, want.steps, want.distance,
                        want.end_of_run);
               $display("%0t:      got kind %0d turn %0d steps %0d distance %0d end %0d",
                        $time, got.cmd_kind, got.turn, got.steps, got.distance,
                        got.end_of_run);
            end
         end
      endfunction

      function int pending();
         return expected_cmds.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   motion_scoreboard sb = new();
   bit idle_on = 1'b1;
   bit stall_request = 1'b0;
   int settings_used = 0;
   logic [COORD_BITS-1:0] cur_row = '0;
   logic [COORD_BITS-1:0] cur_col = '0;

   path_to_motion_commands_top DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_word,
      .rsp_valid, .rsp_ready, .rsp_word,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   // command receiver with random back-pressure and one long hold-off
   initial begin : command_sink
      int gap_left;
      int hold_left;
      gap_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_command(rsp_word);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
               gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 3);
         end
      end
   end

   // stop a run in which nothing moves any more
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // random sender gap before a word
   task automatic sender_pause();
      int n;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // offer one cell word and hold it until accepted
   task automatic send_cell(input logic [COORD_BITS-1:0] r, input logic [COORD_BITS-1:0] c,
                            input logic last);
      req_word_type w;
      w.row = r;
      w.col = c;
      w.last_cell = last;
      sender_pause();
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_cell(w);
      cur_row = r;
      cur_col = c;
   endtask

   // n unit steps in one heading, last flag on the final one if asked
   task automatic walk(input logic [HEAD_BITS-1:0] h, input int n, input logic close);
      int i;
      logic [COORD_BITS-1:0] r;
      logic [COORD_BITS-1:0] c;
      for (i = 0; i < n; i++) begin
         r = cur_row;
         c = cur_col;
         case (h)
            HEAD_N:  r = r - 1'b1;
            HEAD_E:  c = c + 1'b1;
            HEAD_S:  r = r + 1'b1;
            default: c = c - 1'b1;
         endcase
         send_cell(r, c, close && (i == n - 1));
      end
   endtask

   task automatic jump(input logic [COORD_BITS-1:0] dr, input logic [COORD_BITS-1:0] dc,
                       input logic close);
      send_cell(cur_row + dr, cur_col + dc, close);
   endtask

   // drop valid and let every expected command drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // write all registers, junk in the unused upper bits, plus the spare index
   task automatic configure(input logic [CELL_BITS-1:0] size_v, input logic en_v,
                            input logic [HEAD_BITS-1:0] head_v);
      logic [CSR_DATA_BITS-1:0] junk;
      wait_idle();
      junk = 16'($urandom);
      csr_put(CSR_CELL_SIZE, size_v);
      csr_put(CSR_START_ENABLE, {junk[15:1], en_v});
      csr_put(CSR_START_HEAD, {~junk[15:2], head_v});
      csr_put(CSR_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_path();
      int kind;
      int legs;
      int len;
      int i;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // noise: unrelated cells, any of them may close the path
         len = $urandom_range(1, 4);
         for (i = 0; i < len; i++)
            send_cell(16'($urandom), 16'($urandom), (i == len - 1) ? 1'b1 : 1'($urandom));
      end else if (kind == 1) begin
         // broken start, the rest of the path is dead
         send_cell(16'($urandom), 16'($urandom), 1'b0);
         jump(16'($urandom_range(2, 5)), 16'($urandom_range(0, 1)), 1'b0);
         walk(2'($urandom), $urandom_range(1, 3), 1'b1);
      end else if (kind == 2) begin
         send_cell(16'($urandom), 16'($urandom), 1'b1);
      end else begin
         // well-formed path of a few legs, now and then a skipped jump
         send_cell(16'($urandom), 16'($urandom), 1'b0);
         legs = $urandom_range(1, 4);
         for (i = 0; i < legs; i++) begin
            if (i > 0 && $urandom_range(0, 7) == 0)
               jump(16'($urandom_range(0, 2)), 16'd2, 1'b0);
            walk(2'($urandom), $urandom_range(1, 4), i == legs - 1);
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      int mark;
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-cell path at the top corner
      send_cell(16'hFFFF, 16'hFFFF, 1'b1);
      // first step wraps the row, so it is not a unit step
      send_cell(16'h0000, 16'h0000, 1'b0);
      send_cell(16'hFFFF, 16'h0000, 1'b0);
      walk(HEAD_E, 1, 1'b1);
      // every turn kind, plus a skipped jump inside a run
      send_cell(16'h8000, 16'h7FFF, 1'b0);
      walk(HEAD_N, 2, 1'b0);
      walk(HEAD_E, 1, 1'b0);
      walk(HEAD_S, 2, 1'b0);
      walk(HEAD_E, 1, 1'b0);
      walk(HEAD_W, 2, 1'b0);
      jump(16'h0000, 16'hFFFD, 1'b0);
      walk(HEAD_W, 1, 1'b1);

      // start heading equal to the first heading: no rotate
      configure(16'hFFFF, 1'b1, HEAD_W);
      send_cell(16'h0000, 16'hFFFF, 1'b0);
      walk(HEAD_W, 2, 1'b1);
      // start heading differs: rotate first
      send_cell(16'h0001, 16'h0000, 1'b0);
      walk(HEAD_N, 1, 1'b1);
      // zero cell size, u-turn from the start heading
      configure(16'h0000, 1'b1, HEAD_S);
      send_cell(16'h0100, 16'h0100, 1'b0);
      walk(HEAD_N, 2, 1'b0);
      walk(HEAD_E, 1, 1'b1);

      // random paths over several register settings
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       configure(16'h0001, 1'b0, HEAD_N);
            1:       configure(16'hFFFF, 1'b1, HEAD_E);
            2:       configure(16'($urandom), 1'b1, HEAD_S);
            3:       configure(16'($urandom), 1'b1, HEAD_W);
            default: configure(CELL_SIZE_RESET, 1'b0, 2'($urandom));
         endcase
         idle_on = (phase != 2);
         mark = sb.cells_taken;
         while (sb.cells_taken - mark < 10) random_path();
      end
      idle_on = 1'b1;

      // long receiver hold-off while a zigzag path keeps the input busy
      configure(16'($urandom), 1'b1, 2'($urandom));
      idle_on = 1'b0;
      stall_request = 1'b1;
      send_cell(16'd1000, 16'd1000, 1'b0);
      for (i = 0; i < 12; i++) begin
         walk(HEAD_E, 1, 1'b0);
         walk(HEAD_N, 1, 1'b0);
      end
      walk(HEAD_E, 1, 1'b1);
      idle_on = 1'b1;

      // long straight run at the largest cell size
      configure(16'hFFFF, 1'b0, HEAD_N);
      send_cell(16'h4000, 16'h0000, 1'b0);
      walk(HEAD_E, 20, 1'b1);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d cells in %0d paths under %0d register settings",
               sb.cells_taken, sb.paths_closed, settings_used);
      $display("checked %0d commands, %0d failures, %0d left waiting",
               sb.cmds_checked, sb.failures, sb.pending());
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
